// File: sv/ral_pkg.sv
// ----------------------------------------------------------------------------
// ral_pkg: region address lookup shared definitions
// Field widths, table geometry, mode and status codes, and the table entry
// and probe result types.
// ----------------------------------------------------------------------------
package ral_pkg;

   localparam int MAX_REGIONS    = 1024;
   localparam int WORD_BYTES     = 8;

   localparam int MODE_W         = 2;
   localparam int ADDR_W         = 48;
   localparam int BYTES_W        = 49;
   localparam int END_W          = 50;
   localparam int STATUS_W       = 2;
   localparam int REGION_INDEX_W = 10;
   localparam int WORD_INDEX_W   = 45;

   localparam int IDX_W          = $clog2(MAX_REGIONS);
   localparam int CNT_W          = $clog2(MAX_REGIONS + 1);
   localparam int WORD_SHIFT     = $clog2(WORD_BYTES);

   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_HIT      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_APPENDED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   typedef struct packed {
      logic [END_W-1:0]  region_end;
      logic [ADDR_W-1:0] base;
   } entry_type;

   typedef struct packed {
      logic above;
      logic below;
   } probe_result_type;

endpackage

// File: sv/ral_req_if.sv
// ----------------------------------------------------------------------------
// ral_req_if: request channel
// Valid/ready channel carrying one request word: mode, address, region size.
// ----------------------------------------------------------------------------
interface ral_req_if;

   logic                         valid;
   logic                         ready;
   logic [ral_pkg::MODE_W-1:0]   mode;
   logic [ral_pkg::ADDR_W-1:0]   address;
   logic [ral_pkg::BYTES_W-1:0]  region_bytes;

   modport source (output valid, output mode, output address, output region_bytes,
                   input ready);
   modport sink   (input valid, input mode, input address, input region_bytes,
                   output ready);

endinterface

// File: sv/ral_rsp_if.sv
// ----------------------------------------------------------------------------
// ral_rsp_if: response channel
// Valid/ready channel carrying one response word: status, region and word index.
// ----------------------------------------------------------------------------
interface ral_rsp_if;

   logic                               valid;
   logic                               ready;
   logic [ral_pkg::STATUS_W-1:0]       status;
   logic [ral_pkg::REGION_INDEX_W-1:0] region_index;
   logic [ral_pkg::WORD_INDEX_W-1:0]   word_index;

   modport source (output valid, output status, output region_index, output word_index,
                   input ready);
   modport sink   (input valid, input status, input region_index, input word_index,
                   output ready);

endinterface

// File: sv/ral_probe.sv
// ----------------------------------------------------------------------------
// ral_probe: region compare unit
// Compares an address against one table entry and forms the word offset
// from the entry base.
// ----------------------------------------------------------------------------
module ral_probe (
   input  logic [ral_pkg::ADDR_W-1:0]       address,
   input  ral_pkg::entry_type               entry,
   output ral_pkg::probe_result_type        result,
   output logic [ral_pkg::WORD_INDEX_W-1:0] word_index
);
   import ral_pkg::*;

   logic [ADDR_W-1:0] offset;
   logic [ADDR_W-1:0] shifted;

   assign result.above = END_W'(address) >= entry.region_end;
   assign result.below = address < entry.base;

   assign offset     = address - entry.base;
   assign shifted    = offset >> WORD_SHIFT;
   assign word_index = shifted[WORD_INDEX_W-1:0];

endmodule

// File: sv/region_address_lookup_core.sv
// ----------------------------------------------------------------------------
// region_address_lookup_core: region table with binary-search lookup
// Flow: append, clear and unused modes and out-of-range lookups answer from
//   DECODE; other lookups run at most 11 search probes in PROBE, then respond.
// Throughput: one word in flight; the next word is taken the cycle after the
//   response handshake. Each probe reads one entry through the table's read port.
// Reset: the region count clears synchronously; the table itself is not cleared.
// ----------------------------------------------------------------------------
module region_address_lookup_core (
   input  logic      clock,
   input  logic      reset,
   ral_req_if.sink   req_bus,
   ral_rsp_if.source rsp_bus
);
   import ral_pkg::*;

   typedef enum logic [1:0] {IDLE, DECODE, PROBE, RESPOND} state_type;

   state_type                 state_ff,        state_in;
   logic [MODE_W-1:0]         mode_ff,         mode_in;
   logic [ADDR_W-1:0]         address_ff,      address_in;
   logic [BYTES_W-1:0]        bytes_ff,        bytes_in;
   logic [CNT_W-1:0]          count_ff,        count_in;
   logic [ADDR_W-1:0]         first_base_ff,   first_base_in;
   logic [END_W-1:0]          last_end_ff,     last_end_in;
   logic [CNT_W-1:0]          lo_ff,           lo_in;
   logic [CNT_W-1:0]          hi_ff,           hi_in;
   logic [IDX_W-1:0]          mid_ff,          mid_in;
   logic                      rsp_valid_ff,    rsp_valid_in;
   logic [STATUS_W-1:0]       status_ff,       status_in;
   logic [REGION_INDEX_W-1:0] region_index_ff, region_index_in;
   logic [WORD_INDEX_W-1:0]   word_index_ff,   word_index_in;

   entry_type                 table_mem [MAX_REGIONS];
   entry_type                 rd_entry_ff;
   logic                      wr_en;
   logic [END_W-1:0]          new_end;

   probe_result_type          probe;
   logic [WORD_INDEX_W-1:0]   probe_word;
   logic [CNT_W-1:0]          next_lo;
   logic [CNT_W-1:0]          next_hi;

   function automatic logic [IDX_W-1:0] midpoint(input logic [CNT_W-1:0] low,
                                                 input logic [CNT_W-1:0] high);
      logic [CNT_W:0] sum;
      sum = {1'b0, low} + {1'b0, high} - 1'b1;
      return IDX_W'(sum >> 1);
   endfunction

   ral_probe u_probe (
      .address    (address_ff),
      .entry      (rd_entry_ff),
      .result     (probe),
      .word_index (probe_word)
   );

   assign new_end = END_W'(address_ff) + END_W'(bytes_ff);

   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      address_in      = address_ff;
      bytes_in        = bytes_ff;
      count_in        = count_ff;
      first_base_in   = first_base_ff;
      last_end_in     = last_end_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      rsp_valid_in    = rsp_valid_ff;
      status_in       = status_ff;
      region_index_in = region_index_ff;
      word_index_in   = word_index_ff;
      wr_en           = 1'b0;
      next_lo         = lo_ff;
      next_hi         = hi_ff;

      unique case (state_ff)
         IDLE: begin
            if (req_bus.valid) begin
               mode_in    = req_bus.mode;
               address_in = req_bus.address;
               bytes_in   = req_bus.region_bytes;
               state_in   = DECODE;
            end
         end
         DECODE: begin
            region_index_in = '0;
            word_index_in   = '0;
            status_in       = STATUS_MISS;
            state_in        = RESPOND;
            rsp_valid_in    = 1'b1;
            unique case (mode_ff)
               MODE_APPEND: begin
                  if (count_ff >= CNT_W'(MAX_REGIONS)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en       = 1'b1;
                     count_in    = count_ff + 1'b1;
                     last_end_in = new_end;
                     status_in   = STATUS_APPENDED;
                     if (count_ff == '0) begin
                        first_base_in = address_ff;
                     end
                  end
               end
               MODE_LOOKUP: begin
                  if (count_ff != '0 && address_ff >= first_base_ff &&
                      END_W'(address_ff) < last_end_ff) begin
                     lo_in        = '0;
                     hi_in        = count_ff;
                     mid_in       = midpoint('0, count_ff);
                     state_in     = PROBE;
                     rsp_valid_in = 1'b0;
                  end
               end
               MODE_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         PROBE: begin
            priority if (probe.above) begin
               next_lo = CNT_W'(mid_ff) + 1'b1;
            end else if (probe.below) begin
               next_hi = CNT_W'(mid_ff);
            end else begin
               status_in       = STATUS_HIT;
               region_index_in = REGION_INDEX_W'(mid_ff);
               word_index_in   = probe_word;
               state_in        = RESPOND;
               rsp_valid_in    = 1'b1;
            end
            if (probe.above || probe.below) begin
               if (next_lo >= next_hi) begin
                  state_in     = RESPOND;
                  rsp_valid_in = 1'b1;
               end else begin
                  lo_in  = next_lo;
                  hi_in  = next_hi;
                  mid_in = midpoint(next_lo, next_hi);
               end
            end
         end
         RESPOND: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff         <= mode_in;
      address_ff      <= address_in;
      bytes_ff        <= bytes_in;
      first_base_ff   <= first_base_in;
      last_end_ff     <= last_end_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      status_ff       <= status_in;
      region_index_ff <= region_index_in;
      word_index_ff   <= word_index_in;
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[count_ff[IDX_W-1:0]] <= '{region_end: new_end, base: address_ff};
      end
      rd_entry_ff <= table_mem[mid_in];
   end

   assign req_bus.ready        = (state_ff == IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.region_index = region_index_ff;
   assign rsp_bus.word_index   = word_index_ff;

endmodule

// File: sv/ral_checker.sv
// ----------------------------------------------------------------------------
// ral_checker: port-level checks for the region lookup core
// Watches the request and response channels and is bound to region_address_lookup_core.
// ----------------------------------------------------------------------------
module ral_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [ral_pkg::STATUS_W-1:0]       rsp_status,
   input logic [ral_pkg::REGION_INDEX_W-1:0] rsp_region_index,
   input logic [ral_pkg::WORD_INDEX_W-1:0]   rsp_word_index
);
   import ral_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_region_index) && $stable(rsp_word_index))
      else $error("response word changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   a_no_same_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response raised the cycle after acceptance");

   a_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_HIT |->
      rsp_region_index == '0 && rsp_word_index == '0)
      else $error("non-hit response carries index fields");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind region_address_lookup_core ral_checker u_ral_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_region_index (rsp_bus.region_index),
   .rsp_word_index   (rsp_bus.word_index)
);
